[hdl/lz78pe_pkg.sv]
package lz78pe_pkg;

	localparam int DICT_ENTRIES = 4096;
	localparam int NUM_CELLS    = 16;
	localparam int BANK_DEPTH   = DICT_ENTRIES / NUM_CELLS;
	localparam int CELL_W       = $clog2(NUM_CELLS);
	localparam int ROW_W        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int IDX_W        = ROW_W + CELL_W;
	localparam int COUNT_W      = $clog2(DICT_ENTRIES + 1);
	localparam int PHRASE_W     = 13;
	localparam int BYTE_W       = 8;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              in_last;
	} byte_item_t;

	typedef struct packed {
		logic [PHRASE_W-1:0] phrase_number;
		logic [BYTE_W-1:0]   tail_byte;
		logic                has_tail;
		logic                token_last;
	} token_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] prefix;
		logic [BYTE_W-1:0]  tail;
	} entry_t;

	// search key and live entry count, held steady for a whole sweep
	typedef struct packed {
		entry_t             pair;
		logic [COUNT_W-1:0] count;
	} key_t;

	typedef struct packed {
		logic              en;
		logic [CELL_W-1:0] lane;
		logic [ROW_W-1:0]  row;
		entry_t            entry;
	} wr_t;

	// probe travelling down the chain, one per dictionary row
	typedef struct packed {
		logic               vld;
		logic               tail;
		logic [ROW_W-1:0]   row;
		logic               hit;
		logic [COUNT_W-1:0] hit_num;
	} probe_t;

endpackage

[hdl/lz78_phrase_encoder_top.sv]
// path: with an empty dictionary a transaction goes straight to the decision, otherwise
//   the rows of the 16-cell chain are swept first, one row entering per cycle, and
//   each cell holds a bank-read register and a compare register; the token is registered
// throughput: one byte at a time, taken only after the previous decision; the token waits in an
//   output register while the next byte is taken
// reset: asynchronous, clears phrase, count and chain control; banks keep stale data
module lz78_phrase_encoder_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  lz78pe_pkg::byte_item_t  byte_item,
	output logic                    token_valid,
	input  logic                    token_stall,
	output lz78pe_pkg::token_item_t token_item
);

	lz78pe_pkg::key_t   key;
	lz78pe_pkg::wr_t    wr;
	lz78pe_pkg::probe_t probe [lz78pe_pkg::NUM_CELLS+1];

	lz78pe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item),
		.key         (key),
		.wr          (wr),
		.probe_head  (probe[0]),
		.probe_end   (probe[lz78pe_pkg::NUM_CELLS])
	);

	for (genvar i = 0; i < lz78pe_pkg::NUM_CELLS; i++) begin : g_cell
		lz78pe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (lz78pe_pkg::CELL_W'(i)),
			.key       (key),
			.wr        (wr),
			.probe_in  (probe[i]),
			.probe_out (probe[i+1])
		);
	end

endmodule

[hdl/lz78pe_cell.sv]
module lz78pe_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lz78pe_pkg::CELL_W-1:0] idx,
	input  lz78pe_pkg::key_t           key,
	input  lz78pe_pkg::wr_t            wr,
	input  lz78pe_pkg::probe_t         probe_in,
	output lz78pe_pkg::probe_t         probe_out
);

	lz78pe_pkg::entry_t bank [lz78pe_pkg::BANK_DEPTH];
	lz78pe_pkg::entry_t rd_q;
	lz78pe_pkg::probe_t probe_s1;
	lz78pe_pkg::probe_t probe_q;

	logic [lz78pe_pkg::IDX_W-1:0]   ent_idx;
	logic [lz78pe_pkg::COUNT_W-1:0] ent_num;
	logic                           in_range;
	logic                           local_hit;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.lane == idx)) begin
			bank[wr.row] <= wr.entry;
		end
		rd_q <= bank[probe_in.row];
	end

	assign ent_idx   = {probe_s1.row, idx};
	assign ent_num   = lz78pe_pkg::COUNT_W'(ent_idx);
	assign in_range  = ent_num < key.count;
	assign local_hit = probe_s1.vld && in_range && (rd_q == key.pair);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s1 <= '0;
			probe_q  <= '0;
		end else begin
			probe_s1        <= probe_in;
			probe_q.vld     <= probe_s1.vld;
			probe_q.tail    <= probe_s1.tail;
			probe_q.row     <= probe_s1.row;
			probe_q.hit     <= probe_s1.hit || local_hit;
			probe_q.hit_num <= local_hit ?
				lz78pe_pkg::COUNT_W'(ent_num + lz78pe_pkg::COUNT_W'(1)) : probe_s1.hit_num;
		end
	end

	assign probe_out = probe_q;

endmodule

[hdl/lz78pe_ctrl.sv]
module lz78pe_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  lz78pe_pkg::byte_item_t  byte_item,
	output logic                    token_valid,
	input  logic                    token_stall,
	output lz78pe_pkg::token_item_t token_item,
	output lz78pe_pkg::key_t        key,
	output lz78pe_pkg::wr_t         wr,
	output lz78pe_pkg::probe_t      probe_head,
	input  lz78pe_pkg::probe_t      probe_end
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [lz78pe_pkg::COUNT_W-1:0]  phrase_q;
	logic [lz78pe_pkg::COUNT_W-1:0]  count_q;
	logic [lz78pe_pkg::BYTE_W-1:0]   byte_q;
	logic                            last_q;
	logic [lz78pe_pkg::ROW_W-1:0]    row_q;
	logic                            hit_q;
	logic [lz78pe_pkg::COUNT_W-1:0]  hit_num_q;
	lz78pe_pkg::token_item_t         token_q;
	logic                            token_valid_q;

	logic                            accept;
	logic                            out_free;
	logic                            extend;
	logic                            load;
	logic                            room;
	logic [lz78pe_pkg::COUNT_W-1:0]  cnt_m1;
	logic [lz78pe_pkg::ROW_W-1:0]    last_row;

	assign byte_stall = (state_q != S_IDLE);
	assign accept     = byte_valid && !byte_stall;
	assign out_free   = !token_valid_q || !token_stall;
	assign extend     = hit_q && !last_q;
	assign load       = (state_q == S_DECIDE) && !extend && out_free;
	assign room       = count_q < lz78pe_pkg::COUNT_W'(lz78pe_pkg::DICT_ENTRIES);
	assign cnt_m1     = lz78pe_pkg::COUNT_W'(count_q - lz78pe_pkg::COUNT_W'(1));
	assign last_row   = cnt_m1[lz78pe_pkg::CELL_W +: lz78pe_pkg::ROW_W];

	assign key.pair.prefix = phrase_q;
	assign key.pair.tail   = byte_q;
	assign key.count       = count_q;

	assign wr.en           = load && !hit_q && room;
	assign wr.lane         = count_q[lz78pe_pkg::CELL_W-1:0];
	assign wr.row          = count_q[lz78pe_pkg::CELL_W +: lz78pe_pkg::ROW_W];
	assign wr.entry.prefix = phrase_q;
	assign wr.entry.tail   = byte_q;

	assign probe_head.vld     = (state_q == S_SEARCH);
	assign probe_head.tail    = (row_q == last_row);
	assign probe_head.row     = row_q;
	assign probe_head.hit     = 1'b0;
	assign probe_head.hit_num = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phrase_q  <= '0;
			count_q   <= '0;
			byte_q    <= '0;
			last_q    <= 1'b0;
			row_q     <= '0;
			hit_q     <= 1'b0;
			hit_num_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_q <= byte_item.in_byte;
						last_q <= byte_item.in_last;
						row_q  <= '0;
						hit_q  <= 1'b0;
						if (count_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					row_q <= row_q + 1'b1;
					if (row_q == last_row) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (probe_end.vld && probe_end.tail) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (extend) begin
						phrase_q <= hit_num_q;
						state_q  <= S_IDLE;
					end else if (out_free) begin
						phrase_q <= '0;
						state_q  <= S_IDLE;
						if (last_q) begin
							count_q <= '0;
						end else if (room) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (probe_end.vld && probe_end.hit) begin
				hit_q     <= 1'b1;
				hit_num_q <= probe_end.hit_num;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
		end else if (load) begin
			token_valid_q <= 1'b1;
		end else if (token_valid_q && !token_stall) begin
			token_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (hit_q) begin
				token_q.phrase_number <= lz78pe_pkg::PHRASE_W'(hit_num_q);
				token_q.tail_byte     <= '0;
				token_q.has_tail      <= 1'b0;
				token_q.token_last    <= 1'b1;
			end else begin
				token_q.phrase_number <= lz78pe_pkg::PHRASE_W'(phrase_q);
				token_q.tail_byte     <= byte_q;
				token_q.has_tail      <= 1'b1;
				token_q.token_last    <= last_q;
			end
		end
	end

	assign token_valid = token_valid_q;
	assign token_item  = token_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lz78pe_pkg::COUNT_W'(lz78pe_pkg::DICT_ENTRIES))
		else $error("entry count beyond dictionary size");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_DECIDE) && !hit_q && room)
		else $error("entry written without room or after a match");

	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		probe_end.vld |-> (state_q == S_SEARCH || state_q == S_DRAIN))
		else $error("probe left the chain outside a sweep");

	a_token_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(token_valid_q) |-> $past(state_q == S_DECIDE))
		else $error("token loaded outside decision");

endmodule
